// ===== design/rbhe_pkg.sv =====
// Package for the record binary heap engine.
// Holds record types, command and status codes, and store constants.
package rbhe_pkg;

  localparam int DEF_STORE_DEPTH = 64;
  localparam int REC_W = 44;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_BUILD  = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_READ   = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] REG_KEY_SELECT = 2'd0;
  localparam logic [1:0] REG_HEAP_ORDER = 2'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [9:0]  height;
    logic [9:0]  weight;
  } rec_t;

  typedef struct packed {
    logic key_select;
    logic heap_order;
  } cfg_t;

endpackage

// ===== design/rbhe_if.sv =====
// Valid/ready channel interfaces for the heap engine.
// The input interface imports rbhe_pkg.
interface rbhe_in_if import rbhe_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] rec_id;
  logic [7:0]  rec_age;
  logic [9:0]  rec_height;
  logic [9:0]  rec_weight;
  logic [5:0]  read_index;
  modport source (output valid, command, rec_id, rec_age, rec_height, rec_weight,
                  read_index, input ready);
  modport sink (input valid, command, rec_id, rec_age, rec_height, rec_weight,
                read_index, output ready);
endinterface

interface rbhe_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic [15:0] out_id;
  logic [7:0]  out_age;
  logic [9:0]  out_height;
  logic [9:0]  out_weight;
  modport source (output valid, status, entry_count, out_id, out_age, out_height,
                  out_weight, input ready);
  modport sink (input valid, status, entry_count, out_id, out_age, out_height,
                out_weight, output ready);
endinterface

// ===== design/rbhe_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module rbhe_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/rbhe_cfg.sv =====
// APB-style configuration registers of the heap engine.
// Depends on rbhe_pkg.
module rbhe_cfg import rbhe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  cfg_t cfg_r;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_KEY_SELECT[0]: cfg_r.key_select <= pwdata[0];
        REG_HEAP_ORDER[0]: cfg_r.heap_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_KEY_SELECT[0]: prdata[0] = cfg_r.key_select;
      REG_HEAP_ORDER[0]: prdata[0] = cfg_r.heap_order;
      default: ;
    endcase
  end
endmodule

// ===== design/rbhe_seq.sv =====
// Sequencer of the heap engine: decodes commands and runs Floyd builds
// through one shared compare unit over a single-port record RAM. Uses rbhe_pkg.
module rbhe_seq import rbhe_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  rbhe_in_if.sink          in_ch,
  rbhe_out_if.source       out_ch
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [4:0] {
    S_IDLE, S_APPEND, S_BLD_INIT, S_P_NEXT, S_RD_P, S_WT_P, S_RD_L, S_WT_L,
    S_RD_R, S_WT_R, S_SWAP1, S_SWAP2, S_RM_RD0, S_RM_WT0, S_RM_RDL, S_RM_WTL,
    S_RM_WR0, S_RM_WRL, S_RD_WAIT, S_RD_DONE, S_OUT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  cmd_t            cmd_r;
  rec_t            inrec_r;
  logic [5:0]      ridx_r;
  logic            phase2_r;
  logic [CW-1:0]   p_r;
  logic [AW-1:0]   cur_r, best_r;
  rec_t            cur_rec_r, best_rec_r, shown_r;
  logic [1:0]      status_r;
  logic            ovalid_r;

  logic            we;
  logic [AW-1:0]   addr;
  rec_t            wdata, rdata;
  logic [CW:0]     lidx, ridx;
  logic [9:0]      kb, kr;
  logic            wins;

  rbhe_ram #(.WIDTH(REC_W), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign lidx = {cur_r, 1'b1} + (CW + 1)'(0);
  assign ridx = lidx + (CW + 1)'(1);
  assign kb = cfg.key_select ? best_rec_r.weight : {2'b0, best_rec_r.age};
  assign kr = cfg.key_select ? rdata.weight : {2'b0, rdata.age};
  assign wins = cfg.heap_order ? (kr > kb) : (kr < kb);

  always_comb begin
    we = 1'b0;
    addr = cur_r;
    wdata = inrec_r;
    unique case (state_r)
      S_APPEND: begin we = 1'b1; addr = count_r[AW-1:0]; end
      S_RD_P: addr = cur_r;
      S_RD_L: addr = lidx[AW-1:0];
      S_RD_R: addr = ridx[AW-1:0];
      S_SWAP1: begin we = 1'b1; addr = cur_r; wdata = best_rec_r; end
      S_SWAP2: begin we = 1'b1; addr = best_r; wdata = cur_rec_r; end
      S_RM_RD0: addr = '0;
      S_RM_RDL: addr = AW'(count_r - CW'(1));
      S_RM_WR0: begin we = 1'b1; addr = '0; wdata = best_rec_r; end
      S_RM_WRL: begin we = 1'b1; addr = AW'(count_r - CW'(1)); wdata = cur_rec_r; end
      S_RD_WAIT: addr = AW'(ridx_r);
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.status = status_r;
  assign out_ch.entry_count = 7'(count_r);
  assign out_ch.out_id = shown_r.id;
  assign out_ch.out_age = shown_r.age;
  assign out_ch.out_height = shown_r.height;
  assign out_ch.out_weight = shown_r.weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          cmd_r <= cmd_t'(in_ch.command);
          inrec_r <= '{in_ch.rec_id, in_ch.rec_age, in_ch.rec_height, in_ch.rec_weight};
          ridx_r <= in_ch.read_index;
          status_r <= ST_OK;
          shown_r <= '0;
          phase2_r <= 1'b0;
          unique case (cmd_t'(in_ch.command))
            CMD_CLEAR: begin count_r <= '0; state_r <= S_OUT; end
            CMD_APPEND, CMD_INSERT:
              if (count_r >= CW'(STORE_DEPTH)) begin
                status_r <= ST_FULL; state_r <= S_OUT;
              end else state_r <= S_APPEND;
            CMD_BUILD: state_r <= S_BLD_INIT;
            CMD_REMOVE:
              if (count_r == '0) begin
                status_r <= ST_EMPTY; state_r <= S_OUT;
              end else state_r <= S_BLD_INIT;
            CMD_READ:
              if (count_r == '0) begin
                status_r <= ST_EMPTY; state_r <= S_OUT;
              end else if (XW'(in_ch.read_index) >= XW'(count_r)) begin
                status_r <= ST_RANGE; state_r <= S_OUT;
              end else state_r <= S_RD_WAIT;
            default: state_r <= S_OUT;
          endcase
        end
        S_APPEND: begin
          count_r <= count_r + CW'(1);
          state_r <= (cmd_r == CMD_INSERT) ? S_BLD_INIT : S_OUT;
        end
        S_BLD_INIT: begin
          p_r <= count_r >> 1;
          state_r <= S_P_NEXT;
        end
        S_P_NEXT:
          if (p_r == '0) begin
            if (cmd_r == CMD_REMOVE && !phase2_r) state_r <= S_RM_RD0;
            else state_r <= S_OUT;
          end else begin
            cur_r <= AW'(p_r - CW'(1));
            p_r <= p_r - CW'(1);
            state_r <= S_RD_P;
          end
        S_RD_P: state_r <= S_WT_P;
        S_WT_P: begin
          cur_rec_r <= rdata; best_rec_r <= rdata; best_r <= cur_r;
          if (lidx < (CW + 1)'(count_r)) state_r <= S_RD_L;
          else state_r <= S_P_NEXT;
        end
        S_RD_L: state_r <= S_WT_L;
        S_WT_L: begin
          if (wins) begin best_rec_r <= rdata; best_r <= lidx[AW-1:0]; end
          if (ridx < (CW + 1)'(count_r)) state_r <= S_RD_R;
          else state_r <= S_SWAP1;
        end
        S_RD_R: state_r <= S_WT_R;
        S_WT_R: begin
          if (wins) begin best_rec_r <= rdata; best_r <= ridx[AW-1:0]; end
          state_r <= S_SWAP1;
        end
        S_SWAP1: state_r <= (best_r == cur_r) ? S_P_NEXT : S_SWAP2;
        S_SWAP2: begin cur_r <= best_r; state_r <= S_RD_P; end
        S_RM_RD0: state_r <= S_RM_WT0;
        S_RM_WT0: begin cur_rec_r <= rdata; state_r <= S_RM_RDL; end
        S_RM_RDL: state_r <= S_RM_WTL;
        S_RM_WTL: begin best_rec_r <= rdata; state_r <= S_RM_WR0; end
        S_RM_WR0: state_r <= S_RM_WRL;
        S_RM_WRL: begin
          shown_r <= cur_rec_r;
          count_r <= count_r - CW'(1);
          phase2_r <= 1'b1;
          state_r <= S_BLD_INIT;
        end
        S_RD_WAIT: state_r <= S_RD_DONE;
        S_RD_DONE: begin shown_r <= rdata; state_r <= S_OUT; end
        S_OUT: begin ovalid_r <= 1'b1; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STORE_DEPTH)) else $error("count above depth");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("ready while result pending");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> ovalid_r) else $error("result not raised");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && status_r != ST_OK) |-> shown_r == '0) else $error("record on error");
endmodule

// ===== design/record_binary_heap_engine.sv =====
// Channel   | Dir | Handshake            | Word
// in_       | in  | in_valid/in_ready    | command and record fields
// out_      | out | out_valid/out_ready  | status, count, record
// cfg_      | in  | APB psel/penable     | key_select, heap_order
// A build sifts each parent down, last parent first, swapping at each level and
// reading through the single RAM port used for every read and write.
// Remove-top runs a build, swaps root and last record, shrinks, then builds again.
// Reset is synchronous, active low; the store is undefined until written.
// Input is not ready until the result word has been taken.
module record_binary_heap_engine import rbhe_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rbhe_in_if.sink     in_ch,
  rbhe_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  cfg_t cfg;

  rbhe_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  rbhe_seq #(.STORE_DEPTH(STORE_DEPTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
